@@ sv/rppc_pkg.sv @@
// ----------------------------------------------------------------------------
// rppc_pkg
// shared types and constants of the relief palette pixel colorizer
// ----------------------------------------------------------------------------
package rppc_pkg;

  localparam int GreyW      = 8;
  localparam int AlphaW     = 8;
  localparam int ColorW     = 24;
  localparam int ChanW      = 8;
  localparam int ShadeW     = 4;
  localparam int AddrW      = ShadeW + 1 + GreyW;   // shade, land bit, level
  localparam int LandBit    = GreyW;                // address bit that selects land
  localparam int SumW       = 10;                   // signed emboss difference

  localparam logic [ShadeW-1:0] ShadeNeutral = 4'd8;
  localparam logic [ShadeW-1:0] ShadeMax     = 4'd15;
  localparam logic [SumW-1:0]   FlatBias     = 10'd8;
  localparam logic [SumW-1:0]   SphereBias   = 10'd16;
  localparam logic [ChanW-1:0]  AlphaFull    = 8'd255;

  localparam int DefQueueDepth = 4;

  typedef enum logic {
    OpPixel = 1'b0,
    OpLoad  = 1'b1
  } op_t;

  typedef enum logic {
    CfgReliefEnable = 1'b0,
    CfgSphereMode   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic relief_enable;
    logic sphere_mode;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    op_t                op;
    logic [AddrW-1:0]   addr;    // load address, or sea address of a pixel
    logic [ColorW-1:0]  color;
    logic [AlphaW-1:0]  alpha;
  } qentry_t;

endpackage

@@ sv/rppc_front.sv @@
// ----------------------------------------------------------------------------
// rppc_front
// accepts items, runs the grey delay line and forms palette addresses
// ----------------------------------------------------------------------------
module rppc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rppc_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  input  logic                       in_mode,
  input  logic [rppc_pkg::GreyW-1:0]  in_grey,
  input  logic [rppc_pkg::AlphaW-1:0] in_coast_alpha,
  input  logic                       in_row_start,
  input  logic [rppc_pkg::AddrW-1:0]  in_entry_index,
  input  logic [rppc_pkg::ColorW-1:0] in_entry_color,
  input  logic                       q_full,
  output logic                       in_stall,
  output logic                       push,
  output rppc_pkg::qentry_t          push_entry
);
  import rppc_pkg::*;

  logic [GreyW-1:0]  hist_r [3];
  logic [GreyW-1:0]  hist_nxt [3];
  logic [GreyW-1:0]  head;
  logic              row_clear;
  logic              pixel_acc;
  logic [SumW-1:0]   flat_diff;
  logic [SumW-1:0]   sphere_diff;
  logic [SumW-1:0]   diff;
  logic [ShadeW-1:0] shade;
  op_t               op;

  assign op        = op_t'(in_mode);
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign pixel_acc = push && (op == OpPixel) && cfg.relief_enable;

  // flat maps start every row with an empty delay line
  assign row_clear = !cfg.sphere_mode && in_row_start;
  assign head      = row_clear ? '0 : hist_r[0];

  assign flat_diff   = {2'b00, head} + FlatBias - {2'b00, in_grey};
  assign sphere_diff = {2'b00, head} + SphereBias - {2'b00, in_grey};

  always_comb begin
    diff = cfg.sphere_mode ? {1'b0, sphere_diff[SumW-1:1]} : flat_diff;
    if (cfg.sphere_mode && sphere_diff[SumW-1]) begin
      diff = '0;
    end
    if (!cfg.relief_enable) begin
      shade = ShadeNeutral;
    end else if (diff[SumW-1]) begin
      shade = '0;
    end else if (diff > {{(SumW-ShadeW){1'b0}}, ShadeMax}) begin
      shade = ShadeMax;
    end else begin
      shade = diff[ShadeW-1:0];
    end
  end

  always_comb begin
    hist_nxt[0] = row_clear ? '0 : hist_r[1];
    hist_nxt[1] = row_clear ? '0 : hist_r[2];
    hist_nxt[2] = in_grey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0] <= '0;
      hist_r[1] <= '0;
      hist_r[2] <= '0;
    end else if (pixel_acc) begin
      hist_r[0] <= hist_nxt[0];
      hist_r[1] <= hist_nxt[1];
      hist_r[2] <= hist_nxt[2];
    end
  end

  always_comb begin
    push_entry.op    = op;
    push_entry.color = in_entry_color;
    push_entry.alpha = in_coast_alpha;
    if (op == OpLoad) begin
      push_entry.addr = in_entry_index;
    end else begin
      push_entry.addr = {shade, 1'b0, in_grey};
    end
  end

endmodule

@@ sv/rppc_queue.sv @@
// ----------------------------------------------------------------------------
// rppc_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module rppc_queue #(
  parameter int Depth = rppc_pkg::DefQueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rppc_pkg::qentry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output rppc_pkg::qentry_t head_entry
);
  import rppc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qentry_t          slot_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/rppc_back.sv @@
// ----------------------------------------------------------------------------
// rppc_back
// palette memory, per-channel alpha blend and the output register
// ----------------------------------------------------------------------------
module rppc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  rppc_pkg::qentry_t          q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rppc_pkg::ColorW-1:0] out_pixel_color
);
  import rppc_pkg::*;

  localparam int Depth = 1 << AddrW;
  localparam int Chans = ColorW / ChanW;
  localparam int ProdW = 2 * ChanW;

  logic [ColorW-1:0] palette [Depth];

  logic              advance;
  logic [AddrW-1:0]  land_addr;

  logic              s1_valid_r;
  logic [ColorW-1:0] s1_sea_r, s1_land_r;
  logic [AlphaW-1:0] s1_alpha_r;

  logic              s2_valid_r;
  logic [ProdW-1:0]  s2_land_prod_r [Chans];
  logic [ProdW-1:0]  s2_sea_prod_r  [Chans];

  logic              out_valid_r;
  logic [ColorW-1:0] out_color_r, out_color_nxt;

  logic [AlphaW-1:0] inv_alpha;
  logic [ProdW:0]    blend_sum [Chans];
  logic [ProdW:0]    blend_q   [Chans];

  // the whole back end moves together while the output slot can take a result
  assign advance   = !out_valid_r || !out_stall;
  assign q_pop     = advance && !q_empty;
  assign land_addr = q_head.addr | (AddrW'(1) << LandBit);
  assign inv_alpha = AlphaFull - s1_alpha_r;

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.op == OpLoad)) begin
      palette[q_head.addr] <= q_head.color;
    end
    if (advance) begin
      s1_sea_r  <= palette[q_head.addr];
      s1_land_r <= palette[land_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_alpha_r <= q_head.alpha;
      for (int c = 0; c < Chans; c++) begin
        s2_land_prod_r[c] <= s1_alpha_r * s1_land_r[c*ChanW +: ChanW];
        s2_sea_prod_r[c]  <= inv_alpha * s1_sea_r[c*ChanW +: ChanW];
      end
      out_color_r <= out_color_nxt;
    end
  end

  // floor(x / 255) as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      blend_sum[c] = {1'b0, s2_land_prod_r[c]} + {1'b0, s2_sea_prod_r[c]};
      blend_q[c]   = blend_sum[c] + (blend_sum[c] >> ChanW) + 1'b1;
      out_color_nxt[c*ChanW +: ChanW] = blend_q[c][ProdW-1:ChanW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_pop && (q_head.op == OpPixel);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

@@ sv/relief_palette_pixel_colorizer.sv @@
// path: a pixel accepted goes through a queue slot, then the s1, s2 and output registers, to out_valid
// throughput: one item per cycle when not stalled, set by the palette write and dual read
// load items take a queue slot and pass the back end but give no output transfer
// a stalled valid output holds the back end; the front keeps accepting until the queue fills
// reset: synchronous active-low; clears queue, pipeline valids, delay line and config
// the palette has no reset and holds garbage until loaded
// ----------------------------------------------------------------------------
// relief_palette_pixel_colorizer
// colorizes height-map pixels from a shaded sea/land palette with coast blend
// ----------------------------------------------------------------------------
module relief_palette_pixel_colorizer #(
  parameter int QueueDepth = rppc_pkg::DefQueueDepth
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [rppc_pkg::GreyW-1:0]   in_grey,
  input  logic [rppc_pkg::AlphaW-1:0]  in_coast_alpha,
  input  logic                        in_row_start,
  input  logic [rppc_pkg::AddrW-1:0]   in_entry_index,
  input  logic [rppc_pkg::ColorW-1:0]  in_entry_color,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rppc_pkg::ColorW-1:0]  out_pixel_color
);
  import rppc_pkg::*;

  cfg_t    cfg_r;
  logic    q_push, q_pop, q_full, q_empty;
  qentry_t q_push_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CfgReliefEnable: cfg_r.relief_enable <= cfg_wdata;
        CfgSphereMode:   cfg_r.sphere_mode   <= cfg_wdata;
        default:         cfg_r               <= cfg_r;
      endcase
    end
  end

  rppc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_grey        (in_grey),
    .in_coast_alpha (in_coast_alpha),
    .in_row_start   (in_row_start),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (q_push),
    .push_entry     (q_push_entry)
  );

  rppc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head_entry (q_head)
  );

  rppc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color)
  );

  // a held result must freeze the back end, so nothing leaves the queue
  a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while output transfer stalled");

  // the front only pushes into a queue with room
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");

  // a stalled result stays offered and unchanged
  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pixel_color)))
    else $error("stalled output transfer dropped or changed");

  // reset empties the output slot
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// pixel and palette-load stream through the relief palette colorizer
//
// A directed list covers the field extremes, both item kinds, row starts,
// clamping at both ends of the shade range in flat and globe shading, and a
// grey line that is left alone while relief is off. Random scan rows follow
// under every register setting. A local model of palette, grey line and
// blend predicts each color, and every output transfer is checked in order.
// Both sides idle at random. The receiver holds off twice for a long stretch,
// and the sender pauses once until every color has come back.
// ----------------------------------------------------------------------------
module tb_top;
  import rppc_pkg::*;

  localparam int ItemTarget   = 1650;
  localparam int PhaseCount   = 6;
  localparam int DrainCycles  = 12;
  localparam int HoldCycles   = 80;
  localparam int CycleLimit   = 400000;
  localparam int PaletteDepth = 1 << AddrW;

  typedef struct packed {
    op_t               op;
    logic [GreyW-1:0]  grey;
    logic [AlphaW-1:0] alpha;
    logic              row_start;
    logic [AddrW-1:0]  index;
    logic [ColorW-1:0] color;
  } pix_item_t;

  typedef struct packed {
    pix_item_t         item;
    logic              relief;
    logic              sphere;
    logic              known;
    logic [ColorW-1:0] color_known;
  } dir_step_t;

  localparam dir_step_t DirSteps [22] = '{
    // relief off: extreme palette addresses, then shade 8 with plain sea/land picks
    '{'{OpLoad,  8'hff, 8'hff, 1'b1, 13'd0,    24'h000000}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpLoad,  8'h00, 8'h00, 1'b0, 13'd8191, 24'hffffff}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpLoad,  8'h80, 8'h01, 1'b1, 13'd4096, 24'h123456}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpLoad,  8'h7f, 8'hfe, 1'b0, 13'd4352, 24'hfedcba}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'h00, 1'b1, 13'h1fff, 24'habcdef}, 1'b0, 1'b0, 1'b1, 24'h123456},
    '{'{OpPixel, 8'h00, 8'hff, 1'b0, 13'd0,    24'h000000}, 1'b0, 1'b0, 1'b1, 24'hfedcba},
    '{'{OpLoad,  8'h00, 8'h00, 1'b0, 13'd4351, 24'hffffff}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpLoad,  8'hff, 8'hff, 1'b1, 13'd4607, 24'h000000}, 1'b0, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'hff, 8'hff, 1'b0, 13'h0aaa, 24'h555555}, 1'b0, 1'b0, 1'b1, 24'h000000},
    '{'{OpPixel, 8'hff, 8'h00, 1'b0, 13'h1555, 24'haaaaaa}, 1'b0, 1'b0, 1'b1, 24'hffffff},
    '{'{OpPixel, 8'hff, 8'h80, 1'b0, 13'h0000, 24'hffffff}, 1'b0, 1'b0, 1'b1, 24'h7f7f7f},
    // flat relief: row start clears the line, clamp low and high
    '{'{OpPixel, 8'hff, 8'h4d, 1'b1, 13'h0123, 24'h0f0f0f}, 1'b1, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'hc8, 1'b0, 13'h1abc, 24'hf0f0f0}, 1'b1, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'h00, 1'b0, 13'h0001, 24'h000001}, 1'b1, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'hff, 1'b0, 13'h1000, 24'h800000}, 1'b1, 1'b0, 1'b0, 24'h0},
    '{'{OpPixel, 8'h0a, 8'h63, 1'b1, 13'h0fff, 24'h00ff00}, 1'b1, 1'b0, 1'b0, 24'h0},
    // relief off leaves the line alone
    '{'{OpPixel, 8'h32, 8'h1f, 1'b1, 13'h0777, 24'h123123}, 1'b0, 1'b1, 1'b0, 24'h0},
    // globe relief: no clear on row start, halved difference, clamp low and high
    '{'{OpPixel, 8'h00, 8'hff, 1'b1, 13'h1888, 24'h321321}, 1'b1, 1'b1, 1'b0, 24'h0},
    '{'{OpPixel, 8'hff, 8'h00, 1'b0, 13'h0999, 24'h456456}, 1'b1, 1'b1, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'h80, 1'b0, 13'h1111, 24'h654654}, 1'b1, 1'b1, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'h3c, 1'b0, 13'h0222, 24'h789789}, 1'b1, 1'b1, 1'b0, 24'h0},
    '{'{OpPixel, 8'h00, 8'h99, 1'b0, 13'h1333, 24'h987987}, 1'b1, 1'b1, 1'b0, 24'h0}
  };

  // {relief_enable, sphere_mode} of each random phase
  localparam logic [1:0] PhaseModes [PhaseCount] = '{
    2'b11, 2'b10, 2'b00, 2'b01, 2'b10, 2'b11
  };

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic                cfg_index      = 1'b0;
  logic                cfg_wdata      = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                in_mode        = 1'b0;
  logic [GreyW-1:0]    in_grey        = '0;
  logic [AlphaW-1:0]   in_coast_alpha = '0;
  logic                in_row_start   = 1'b0;
  logic [AddrW-1:0]    in_entry_index = '0;
  logic [ColorW-1:0]   in_entry_color = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [ColorW-1:0]   out_pixel_color;

  // local copy of the block state
  logic [ColorW-1:0]   pal_mem [PaletteDepth];
  bit                  pal_loaded [PaletteDepth];
  logic [GreyW-1:0]    grey_line [3] = '{default: '0};
  logic                relief_on = 1'b0;
  logic                sphere_on = 1'b0;
  logic [ColorW-1:0]   colors_due [$];
  logic [ColorW-1:0]   due_color;

  int n_items    = 0;
  int n_pixels   = 0;
  int n_loads    = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_settings = 0;
  int burst_left = 0;
  int cycles     = 0;

  relief_palette_pixel_colorizer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_grey         (in_grey),
    .in_coast_alpha  (in_coast_alpha),
    .in_row_start    (in_row_start),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shade index the next pixel gets, from the current line and registers
  function automatic logic [ShadeW-1:0] shade_for(logic [GreyW-1:0] g, logic rs);
    int head;
    int d;
    if (!relief_on) return ShadeNeutral;
    head = (!sphere_on && rs) ? 0 : int'(grey_line[0]);
    if (sphere_on) begin
      d = head + int'(SphereBias) - int'(g);
      d = (d < 0) ? 0 : d / 2;
    end else begin
      d = head + int'(FlatBias) - int'(g);
    end
    if (d < 0) d = 0;
    else if (d > int'(ShadeMax)) d = int'(ShadeMax);
    return d[ShadeW-1:0];
  endfunction

  function automatic logic [ColorW-1:0] blend_color(logic [ColorW-1:0] land,
                                                    logic [ColorW-1:0] sea,
                                                    logic [AlphaW-1:0] a);
    logic [ColorW-1:0] mix;
    int ch;
    for (int c = 0; c < ColorW / ChanW; c++) begin
      ch = (int'(a) * int'(land[c*ChanW +: ChanW])
            + (int'(AlphaFull) - int'(a)) * int'(sea[c*ChanW +: ChanW])) / int'(AlphaFull);
      mix[c*ChanW +: ChanW] = ch[ChanW-1:0];
    end
    return mix;
  endfunction

  // sender burst/gap pattern, applied after each transfer
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // offer one item, wait for its transfer and update the local state
  task automatic transfer(input pix_item_t it, input bit known,
                          input logic [ColorW-1:0] known_color);
    logic [ShadeW-1:0] sh;
    in_valid       <= 1'b1;
    in_mode        <= it.op;
    in_grey        <= it.grey;
    in_coast_alpha <= it.alpha;
    in_row_start   <= it.row_start;
    in_entry_index <= it.index;
    in_entry_color <= it.color;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (it.op == OpLoad) begin
      pal_mem[it.index]    = it.color;
      pal_loaded[it.index] = 1'b1;
      n_loads++;
    end else begin
      sh = shade_for(it.grey, it.row_start);
      if (relief_on) begin
        if (!sphere_on && it.row_start) foreach (grey_line[k]) grey_line[k] = '0;
        grey_line[0] = grey_line[1];
        grey_line[1] = grey_line[2];
        grey_line[2] = it.grey;
      end
      colors_due.push_back(known ? known_color
                                 : blend_color(pal_mem[{sh, 1'b1, it.grey}],
                                               pal_mem[{sh, 1'b0, it.grey}], it.alpha));
      n_pixels++;
    end
    pace();
  endtask

  // a pixel first gets loads for any sea or land entry it reads that is still unwritten
  task automatic send_item(input pix_item_t it, input bit known,
                           input logic [ColorW-1:0] known_color);
    logic [ShadeW-1:0] sh;
    pix_item_t ld;
    if (it.op == OpPixel) begin
      sh = shade_for(it.grey, it.row_start);
      for (int land = 0; land < 2; land++) begin
        ld.op        = OpLoad;
        ld.index     = {sh, land[0], it.grey};
        ld.color     = ColorW'($urandom);
        ld.grey      = GreyW'($urandom);
        ld.alpha     = AlphaW'($urandom);
        ld.row_start = 1'($urandom);
        if (!pal_loaded[ld.index]) transfer(ld, 1'b0, '0);
      end
    end
    transfer(it, known, known_color);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    // trailing loads may still be on their way to the palette
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic relief, input logic sphere);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CfgReliefEnable;
    cfg_wdata <= relief;
    @(posedge clk);
    relief_on = relief;
    cfg_index <= CfgSphereMode;
    cfg_wdata <= sphere;
    @(posedge clk);
    sphere_on = sphere;
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        $error("pixel_color: expected none, actual %06h", out_pixel_color);
        n_errors++;
      end else begin
        due_color = colors_due.pop_front();
        n_checked++;
        if (out_pixel_color !== due_color) begin
          $error("pixel_color: expected %06h, actual %06h", due_color, out_pixel_color);
          n_errors++;
        end
      end
    end
  end

  // receiver: random stall spans, plus two long hold-offs once colors flow
  initial begin : receiver
    int span;
    int odds;
    int holds;
    holds = 0;
    forever begin
      if (holds < 2 && n_checked >= ((holds == 0) ? 200 : 900)) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holds++;
      end
      span = $urandom_range(10, 150);
      odds = $urandom_range(0, 3);
      repeat (span) begin
        out_stall <= (odds != 0) && ($urandom_range(1, 4) <= odds);
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL relief_palette_pixel_colorizer");
    $finish;
  end

  initial begin : stimulus
    pix_item_t it;
    int per_phase;
    int goal;
    int row_len;
    int gi;
    bit paused;
    logic [GreyW-1:0] g;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirSteps[i]) begin
      if (DirSteps[i].relief !== relief_on || DirSteps[i].sphere !== sphere_on)
        set_mode(DirSteps[i].relief, DirSteps[i].sphere);
      send_item(DirSteps[i].item, DirSteps[i].known, DirSteps[i].color_known);
    end

    per_phase = (ItemTarget - n_items) / PhaseCount;
    paused = 1'b0;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      set_mode(PhaseModes[phase][1], PhaseModes[phase][0]);
      goal = n_items + per_phase;
      while (n_items < goal) begin
        // sender waits once for every color to come back
        if (phase == 2 && !paused && n_items > goal - per_phase / 2) begin
          drain();
          paused = 1'b1;
        end
        // one scan row: a grey walk with the odd jump, stray loads and broken row starts
        row_len = $urandom_range(1, 40);
        g = GreyW'($urandom);
        for (int k = 0; k < row_len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            it.op        = OpLoad;
            it.index     = AddrW'($urandom);
            it.color     = ColorW'($urandom);
            it.grey      = GreyW'($urandom);
            it.alpha     = AlphaW'($urandom);
            it.row_start = 1'($urandom);
            send_item(it, 1'b0, '0);
          end
          case ($urandom_range(0, 29))
            0: g = '0;
            1: g = '1;
            2: g = GreyW'($urandom);
            default: begin
              gi = int'(g) + int'($urandom_range(0, 24)) - 12;
              gi = (gi < 0) ? 0 : (gi > 255) ? 255 : gi;
              g  = gi[GreyW-1:0];
            end
          endcase
          it.op        = OpPixel;
          it.grey      = g;
          case ($urandom_range(0, 3))
            0:       it.alpha = '0;
            1:       it.alpha = AlphaFull;
            default: it.alpha = AlphaW'($urandom);
          endcase
          it.row_start = (k == 0) ^ ($urandom_range(0, 24) == 0);
          it.index     = AddrW'($urandom);
          it.color     = ColorW'($urandom);
          send_item(it, 1'b0, '0);
        end
      end
    end

    drain();
    $display("covered %0d transfers in: %0d pixels, %0d palette loads, %0d register settings",
             n_items, n_pixels, n_loads, n_settings);
    $display("checked %0d colors, %0d mismatches, %0d cycles", n_checked, n_errors, cycles);
    if (n_errors == 0) begin
      $display("PASS relief_palette_pixel_colorizer");
    end else begin
      $display("FAIL relief_palette_pixel_colorizer");
    end
    $finish;
  end

endmodule

@@ relief_palette_pixel_colorizer.f @@
sv/rppc_pkg.sv
sv/rppc_front.sv
sv/rppc_queue.sv
sv/rppc_back.sv
sv/relief_palette_pixel_colorizer.sv
tb/tb_top.sv
